// File: rtl/bsa_pkg.sv
// Package for the bitmap slot allocator: field widths, command codes,
// register map and the control struct passed from the register block to the core.
// Depends on nothing; every other file of the block uses it.
package bsa_pkg;

   // Default sizing of the bitmap.
   localparam int MAX_BITS_DEFAULT  = 1024;
   localparam int WORD_BITS_DEFAULT = 32;

   // Fixed field widths of the transactions.
   localparam int CMD_W   = 2;
   localparam int SLOT_W  = 10;
   localparam int COUNT_W = 11;

   typedef logic [CMD_W-1:0]   cmd_type;
   typedef logic [SLOT_W-1:0]  slot_type;
   typedef logic [COUNT_W-1:0] count_type;

   // Command codes.
   localparam cmd_type CMD_MARK  = 2'd0;
   localparam cmd_type CMD_CLEAR = 2'd1;
   localparam cmd_type CMD_ALLOC = 2'd2;
   localparam cmd_type CMD_QUERY = 2'd3;

   // Register map: one 32-bit register at byte address 0.
   localparam int        CSR_ADDR_W        = 3;
   localparam int        CSR_DATA_W        = 32;
   localparam logic      REG_BITS_IN_USE   = 1'b0;
   localparam count_type BITS_IN_USE_RESET = 11'd1024;

   // Control from the register block to the core.
   typedef struct packed {
      count_type bits_in_use;
      logic      wipe;
   } csr_ctrl_type;

endpackage

// File: rtl/bsa_channels.sv
// Request and response channel interfaces of the bitmap slot allocator.
// Depends on bsa_pkg for the payload types.
interface bsa_req_if;
   logic               valid;
   logic               ready;
   bsa_pkg::cmd_type   cmd;
   bsa_pkg::slot_type  slot_index;

   modport source (output valid, output cmd, output slot_index, input ready);
   modport sink   (input valid, input cmd, input slot_index, output ready);
endinterface

interface bsa_rsp_if;
   logic                valid;
   logic                ready;
   logic                was_marked;
   logic                found;
   bsa_pkg::slot_type   alloc_slot;
   bsa_pkg::count_type  free_count;
   logic                index_error;

   modport source (output valid, output was_marked, output found, output alloc_slot,
                   output free_count, output index_error, input ready);
   modport sink   (input valid, input was_marked, input found, input alloc_slot,
                   input free_count, input index_error, output ready);
endinterface

// File: rtl/bsa_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Depends on bsa_pkg for its default sizing.
module bsa_ram #(
   parameter int WIDTH = bsa_pkg::WORD_BITS_DEFAULT,
   parameter int DEPTH = bsa_pkg::MAX_BITS_DEFAULT / bsa_pkg::WORD_BITS_DEFAULT,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Read port; data holds until the next read.
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/bsa_csr.sv
// APB-style register block of the bitmap slot allocator: holds bits_in_use and
// signals a bitmap wipe on every write of it. Depends on bsa_pkg.
module bsa_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [bsa_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [bsa_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [bsa_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready,
   output bsa_pkg::csr_ctrl_type              ctrl
);

   bsa_pkg::count_type bits_in_use_ff;
   bsa_pkg::count_type bits_in_use_in;
   logic               reg_sel;
   logic               write_fire;

   // Address decode and write strobe; the port never waits.
   assign reg_sel    = (csr_paddr[bsa_pkg::CSR_ADDR_W-1:2] == bsa_pkg::REG_BITS_IN_USE);
   assign write_fire = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      bits_in_use_in = bits_in_use_ff;
      if (write_fire && reg_sel) begin
         bits_in_use_in = csr_pwdata[bsa_pkg::COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_in_use_ff <= bsa_pkg::BITS_IN_USE_RESET;
      end else begin
         bits_in_use_ff <= bits_in_use_in;
      end
   end

   // Read data; addresses past the register read as zero.
   assign csr_prdata = reg_sel ?
                       {{(bsa_pkg::CSR_DATA_W - bsa_pkg::COUNT_W){1'b0}}, bits_in_use_ff} :
                       '0;

   // The wipe takes effect at the same edge as the register write.
   assign ctrl.bits_in_use = bits_in_use_ff;
   assign ctrl.wipe        = write_fire && reg_sel;

endmodule

// File: rtl/bsa_core.sv
// Core of the bitmap slot allocator: sequencer, word memory read-modify-write,
// full-word summary, marked-slot count and response register.
// Depends on bsa_pkg, bsa_channels and bsa_ram.
module bsa_core #(
   parameter int MAX_BITS  = bsa_pkg::MAX_BITS_DEFAULT,
   parameter int WORD_BITS = bsa_pkg::WORD_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bsa_pkg::csr_ctrl_type ctrl,
   bsa_req_if.sink               req_chan,
   bsa_rsp_if.source             rsp_chan
);

   localparam int NUM_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int IDX_W     = $clog2(MAX_BITS);
   localparam int SX_W      = (IDX_W > bsa_pkg::SLOT_W) ? IDX_W : bsa_pkg::SLOT_W;
   localparam int LIVE_W    = $clog2(MAX_BITS + 1);
   localparam int CMP_W     = (LIVE_W > bsa_pkg::COUNT_W) ? LIVE_W : bsa_pkg::COUNT_W;
   // Exact reciprocal for slot / WORD_BITS over SX_W-bit slot numbers.
   localparam int DIV_SH    = SX_W + BIT_W;
   localparam int DIV_M     = ((1 << DIV_SH) + WORD_BITS - 1) / WORD_BITS;
   localparam int PROD_W    = SX_W + DIV_SH;

   // Sequencer states.
   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_EXEC  = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [WA_W-1:0]       clr_ptr_ff, clr_ptr_in;
   logic [NUM_WORDS-1:0]  summary_ff, summary_in;
   logic [LIVE_W-1:0]     marked_ff, marked_in;

   bsa_pkg::cmd_type      cmd_ff;
   logic [SX_W-1:0]       idx_ff;
   logic [WA_W-1:0]       word_ff;
   logic                  word_hit_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_was_ff;
   logic                  rsp_found_ff;
   bsa_pkg::slot_type     rsp_slot_ff;
   bsa_pkg::count_type    rsp_free_ff;
   logic                  rsp_err_ff;

   logic [CMP_W-1:0]      live_slots;
   logic                  accept;
   logic                  free_word_hit;
   logic [WA_W-1:0]       free_word;
   logic [PROD_W-1:0]     div_prod;
   logic [SX_W-1:0]       div_quot;
   logic [WA_W-1:0]       rd_addr;

   logic [WORD_BITS-1:0]  old_word;
   logic [WORD_BITS-1:0]  new_word;
   logic [SX_W-1:0]       off_full;
   logic [BIT_W-1:0]      bit_off;
   logic                  old_bit;
   logic                  index_err;
   logic                  zero_hit;
   logic [BIT_W-1:0]      zero_pos;
   logic [CMP_W-1:0]      cand;
   logic                  alloc_found;
   logic                  exec_fire;
   logic                  do_write;
   logic [CMP_W-1:0]      free_full;

   logic                  ram_we;
   logic [WA_W-1:0]       ram_waddr;
   logic [WORD_BITS-1:0]  ram_wdata;

   // Live slot count: register values above MAX_BITS act as MAX_BITS.
   assign live_slots = (CMP_W'(ctrl.bits_in_use) > CMP_W'(MAX_BITS)) ?
                       CMP_W'(MAX_BITS) : CMP_W'(ctrl.bits_in_use);

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;

   // Lowest word that is not fully marked, from the summary vector.
   always_comb begin
      free_word_hit = 1'b0;
      free_word     = '0;
      for (int w = NUM_WORDS - 1; w >= 0; w--) begin
         if (!summary_ff[w]) begin
            free_word_hit = 1'b1;
            free_word     = WA_W'(w);
         end
      end
   end

   // Word number of the addressed slot by reciprocal multiplication.
   assign div_prod = PROD_W'(req_chan.slot_index) * PROD_W'(DIV_M);
   assign div_quot = div_prod[PROD_W-1:DIV_SH];
   assign rd_addr  = (req_chan.cmd == bsa_pkg::CMD_ALLOC) ? free_word : div_quot[WA_W-1:0];

   // Execute cycle: the word read at accept is now in the RAM output register.
   assign off_full  = idx_ff - SX_W'(word_ff) * SX_W'(WORD_BITS);
   assign bit_off   = off_full[BIT_W-1:0];
   assign old_bit   = old_word[bit_off];
   assign index_err = (cmd_ff != bsa_pkg::CMD_ALLOC) && (CMP_W'(idx_ff) >= live_slots);

   // Lowest clear bit of the word picked for allocation.
   always_comb begin
      zero_hit = 1'b0;
      zero_pos = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (!old_word[b]) begin
            zero_hit = 1'b1;
            zero_pos = BIT_W'(b);
         end
      end
   end

   assign cand        = CMP_W'(word_ff) * CMP_W'(WORD_BITS) + CMP_W'(zero_pos);
   assign alloc_found = word_hit_ff && zero_hit && (cand < live_slots);

   // Modified word and count update.
   always_comb begin
      new_word  = old_word;
      marked_in = marked_ff;
      case (cmd_ff)
         bsa_pkg::CMD_MARK: begin
            new_word = old_word | (WORD_BITS'(1) << bit_off);
            if (!old_bit) begin
               marked_in = marked_ff + LIVE_W'(1);
            end
         end
         bsa_pkg::CMD_CLEAR: begin
            new_word = old_word & ~(WORD_BITS'(1) << bit_off);
            if (old_bit) begin
               marked_in = marked_ff - LIVE_W'(1);
            end
         end
         bsa_pkg::CMD_ALLOC: begin
            if (alloc_found) begin
               new_word  = old_word | (WORD_BITS'(1) << zero_pos);
               marked_in = marked_ff + LIVE_W'(1);
            end
         end
         default: begin
            new_word  = old_word;
            marked_in = marked_ff;
         end
      endcase
      if (index_err) begin
         new_word  = old_word;
         marked_in = marked_ff;
      end
   end

   // The result leaves for the output register only when that register is free.
   assign exec_fire = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_chan.ready);
   assign do_write  = exec_fire && !index_err && (cmd_ff != bsa_pkg::CMD_QUERY) &&
                      ((cmd_ff != bsa_pkg::CMD_ALLOC) || alloc_found);
   assign free_full = live_slots - CMP_W'(marked_in);

   // Summary bit of the written word follows its new contents.
   always_comb begin
      summary_in = summary_ff;
      if (do_write) begin
         summary_in[word_ff] = &new_word;
      end
   end

   // Memory ports: the clearing pass owns the write port.
   always_comb begin
      if (state_ff == S_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_ptr_ff;
         ram_wdata = '0;
      end else begin
         ram_we    = do_write;
         ram_waddr = word_ff;
         ram_wdata = new_word;
      end
   end

   bsa_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (NUM_WORDS)
   ) u_word_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (accept),
      .raddr (rd_addr),
      .rdata (old_word)
   );

   // Sequencer next state.
   always_comb begin
      state_in   = state_ff;
      clr_ptr_in = clr_ptr_ff;
      case (state_ff)
         S_CLEAR: begin
            clr_ptr_in = clr_ptr_ff + WA_W'(1);
            if (clr_ptr_ff == WA_W'(NUM_WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (exec_fire) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   assign rsp_valid_in = exec_fire ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   // Control state; a bits_in_use write restarts the clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ptr_ff   <= '0;
         summary_ff   <= '0;
         marked_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (ctrl.wipe) begin
            state_ff   <= S_CLEAR;
            clr_ptr_ff <= '0;
            summary_ff <= '0;
            marked_ff  <= '0;
         end else begin
            state_ff   <= state_in;
            clr_ptr_ff <= clr_ptr_in;
            summary_ff <= summary_in;
            if (exec_fire) begin
               marked_ff <= marked_in;
            end
         end
      end
   end

   // Request capture at accept.
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff      <= req_chan.cmd;
         idx_ff      <= SX_W'(req_chan.slot_index);
         word_ff     <= rd_addr;
         word_hit_ff <= free_word_hit;
      end
   end

   // Response payload register.
   always_ff @(posedge clock) begin
      if (exec_fire) begin
         rsp_was_ff   <= (cmd_ff != bsa_pkg::CMD_ALLOC) && !index_err && old_bit;
         rsp_found_ff <= (cmd_ff == bsa_pkg::CMD_ALLOC) && alloc_found;
         rsp_slot_ff  <= ((cmd_ff == bsa_pkg::CMD_ALLOC) && alloc_found) ?
                         cand[bsa_pkg::SLOT_W-1:0] : '0;
         rsp_free_ff  <= free_full[bsa_pkg::COUNT_W-1:0];
         rsp_err_ff   <= index_err;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.was_marked  = rsp_was_ff;
   assign rsp_chan.found       = rsp_found_ff;
   assign rsp_chan.alloc_slot  = rsp_slot_ff;
   assign rsp_chan.free_count  = rsp_free_ff;
   assign rsp_chan.index_error = rsp_err_ff;

endmodule

// File: rtl/bitmap_slot_allocator.sv
// Top level of the bitmap slot allocator: register block and core.
// Depends on bsa_pkg, bsa_channels, bsa_csr and bsa_core.
//
//   Channel   Direction  Handshake               Contents
//   req_chan  in         valid/ready             cmd, slot_index
//   rsp_chan  out        valid/ready             was_marked, found, alloc_slot,
//                                                free_count, index_error
//   csr_*     in/out     APB setup+access, pready=1  bits_in_use at byte address 0
//
// Each request has its bitmap word read from the word memory when it is accepted, then
// modified and written back in the execute state; the next request is taken after that.
// After reset and after every write of bits_in_use a clearing pass zeroes the word
// memory, one word a cycle, ceil(MAX_BITS/WORD_BITS) words (32 by default); req_chan.ready
// stays low during the pass. A response waiting on rsp_chan does not block the next
// request from being accepted; that request completes once the output register frees.
module bitmap_slot_allocator #(
   parameter int MAX_BITS  = bsa_pkg::MAX_BITS_DEFAULT,
   parameter int WORD_BITS = bsa_pkg::WORD_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   bsa_req_if.sink                        req_chan,
   bsa_rsp_if.source                      rsp_chan,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [bsa_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [bsa_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [bsa_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   bsa_pkg::csr_ctrl_type ctrl;

   // Register block.
   bsa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .ctrl        (ctrl)
   );

   // Allocator core.
   bsa_core #(
      .MAX_BITS  (MAX_BITS),
      .WORD_BITS (WORD_BITS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

`ifndef ASSERT_OFF
   // A successful allocation never reports an index error or a marked old bit.
   a_found_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.found) |-> (!rsp_chan.index_error && !rsp_chan.was_marked))
      else $error("allocation result carries error or old mark");

   // An index error leaves no allocation outcome.
   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.index_error) |->
      (!rsp_chan.found && (rsp_chan.alloc_slot == '0) && !rsp_chan.was_marked))
      else $error("index error result carries allocation data");

   // A bits_in_use write starts the clearing pass, so no request is taken next cycle.
   a_wipe_blocks: assert property (@(posedge clock) disable iff (reset)
      ctrl.wipe |=> !req_chan.ready)
      else $error("request accepted right after a bitmap wipe");
`endif

endmodule
